// File: design/tptt_pkg.sv
// Shared types and constants for the two-phase talk timer.
package tptt_pkg;

  localparam logic [15:0] TicksReset = 16'd14648;
  localparam logic [3:0]  LevelMask  = 4'hF;

  typedef enum logic [2:0] {
    MODE_SET_TALK   = 3'd0,
    MODE_SET_QUEST  = 3'd1,
    MODE_RUN_TALK   = 3'd2,
    MODE_TALK_DONE  = 3'd3,
    MODE_RUN_QUEST  = 3'd4,
    MODE_QUEST_DONE = 3'd5
  } tptt_mode_e;

  typedef struct packed {
    logic set_press;
    logic plus_press;
    logic minus_press;
    logic tick;
  } tptt_item_t;

  typedef struct packed {
    logic [3:0] level_leds;
    logic       talk_led;
    logic       green_led;
    logic       red_led;
    logic       blue_led;
    logic [2:0] mode;
  } tptt_res_t;

endpackage

// File: design/tptt_in_if.sv
// Input channel interface: one poll of buttons and timer tick per beat.
interface tptt_in_if;
  logic valid;
  logic ready;
  logic set_press;
  logic plus_press;
  logic minus_press;
  logic tick;

  modport source (output valid, output set_press, output plus_press,
                  output minus_press, output tick, input ready);
  modport sink (input valid, input set_press, input plus_press,
                input minus_press, input tick, output ready);
endinterface

// File: design/tptt_out_if.sv
// Output channel interface: one LED pattern per beat.
interface tptt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] level_leds;
  logic       talk_led;
  logic       green_led;
  logic       red_led;
  logic       blue_led;
  logic [2:0] mode;

  modport source (output valid, output level_leds, output talk_led,
                  output green_led, output red_led, output blue_led,
                  output mode, input ready);
  modport sink (input valid, input level_leds, input talk_led,
                input green_led, input red_led, input blue_led,
                input mode, output ready);
endinterface

// File: design/tptt_in_stage.sv
// Input register stage holding one accepted poll beat.
module tptt_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  tptt_pkg::tptt_item_t item_i,
  output logic                ready_o,
  input  logic                advance_i,
  output logic                valid_o,
  output tptt_pkg::tptt_item_t item_o
);
  import tptt_pkg::*;

  logic       valid_q, valid_d;
  tptt_item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// File: design/tptt_core.sv
// Mode sequencer, minute settings and tick/minute counters of the timer.
module tptt_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 step_i,
  input  tptt_pkg::tptt_item_t item_i,
  output tptt_pkg::tptt_res_t  res_o
);
  import tptt_pkg::*;

  tptt_mode_e  mode_q, mode_d;
  logic [7:0]  talk_q, talk_d;
  logic [7:0]  quest_q, quest_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  min_q, min_d;
  logic        warn_q, warn_d;
  logic [15:0] tpm_q;

  logic [7:0]  target;
  logic [15:0] tick_inc;
  logic [8:0]  min_plus1;

  function automatic logic [7:0] adjust(logic [7:0] v, logic plus, logic minus);
    logic [7:0] r;
    r = v;
    if (plus) begin
      r = v + 8'd1;
    end else if (minus && (v != 8'd0)) begin
      r = v - 8'd1;
    end
    return r;
  endfunction

  assign tick_inc = tick_q + 16'd1;

  // Next state for one poll beat.
  always_comb begin
    mode_d    = mode_q;
    talk_d    = talk_q;
    quest_d   = quest_q;
    tick_d    = tick_q;
    min_d     = min_q;
    warn_d    = warn_q;
    target    = (mode_q == MODE_RUN_QUEST) ? quest_q : talk_q;
    min_plus1 = 9'd0;
    case (mode_q)
      MODE_SET_QUEST: begin
        if (item_i.set_press) begin
          mode_d = MODE_RUN_TALK;
          tick_d = '0;
          min_d  = '0;
          warn_d = 1'b0;
        end else begin
          quest_d = adjust(quest_q, item_i.plus_press, item_i.minus_press);
        end
      end
      MODE_RUN_TALK, MODE_RUN_QUEST: begin
        if (item_i.tick) begin
          if (tick_inc == tpm_q) begin
            tick_d = '0;
            min_d  = min_q + 8'd1;
          end else begin
            tick_d = tick_inc;
          end
        end
        min_plus1 = {1'b0, min_d} + 9'd1;
        if (min_plus1 == {1'b0, target}) begin
          warn_d = 1'b1;
        end
        if (min_d >= target) begin
          mode_d = (mode_q == MODE_RUN_TALK) ? MODE_TALK_DONE : MODE_QUEST_DONE;
        end
      end
      MODE_TALK_DONE, MODE_QUEST_DONE: begin
        if (item_i.set_press) begin
          mode_d = (mode_q == MODE_TALK_DONE) ? MODE_RUN_QUEST : MODE_RUN_TALK;
          tick_d = '0;
          min_d  = '0;
          warn_d = 1'b0;
        end
      end
      default: begin
        // Set talk mode; unused codes fall back to it.
        mode_d = MODE_SET_TALK;
        if (item_i.set_press) begin
          mode_d = MODE_SET_QUEST;
        end else begin
          talk_d = adjust(talk_q, item_i.plus_press, item_i.minus_press);
        end
      end
    endcase
  end

  // LED pattern taken from the updated state.
  always_comb begin
    res_o            = '0;
    res_o.mode       = mode_d;
    res_o.level_leds = min_d[3:0] & LevelMask;
    case (mode_d)
      MODE_SET_TALK: begin
        res_o.level_leds = talk_d[3:0] & LevelMask;
        res_o.talk_led   = 1'b1;
      end
      MODE_SET_QUEST: begin
        res_o.level_leds = quest_d[3:0] & LevelMask;
      end
      MODE_RUN_TALK: begin
        res_o.talk_led  = 1'b1;
        res_o.green_led = 1'b1;
        res_o.red_led   = warn_d;
      end
      MODE_TALK_DONE: begin
        res_o.talk_led = 1'b1;
        res_o.red_led  = 1'b1;
      end
      MODE_RUN_QUEST: begin
        res_o.green_led = 1'b1;
        res_o.red_led   = warn_d;
        res_o.blue_led  = warn_d;
      end
      default: begin
        res_o.red_led = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SET_TALK;
      talk_q  <= '0;
      quest_q <= '0;
      tick_q  <= '0;
      min_q   <= '0;
      warn_q  <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      talk_q  <= talk_d;
      quest_q <= quest_d;
      tick_q  <= tick_d;
      min_q   <= min_d;
      warn_q  <= warn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q <= TicksReset;
    end else if (cfg_we_i) begin
      tpm_q <= cfg_wdata_i;
    end
  end
endmodule

// File: design/tptt_out_fifo.sv
// Two-entry result buffer that decouples the core from output back-pressure.
module tptt_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tptt_pkg::tptt_res_t data_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                ready_i,
  output tptt_pkg::tptt_res_t data_o
);
  import tptt_pkg::*;

  tptt_res_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign space_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  assign wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end
endmodule

// File: design/two_phase_talk_timer.sv
// A poll beat held in the input register updates the mode and counters and is pushed into
// the result buffer at the same edge, once the buffer has space; it is offered from there.
// Throughput: one poll beat per cycle while the result buffer has space; the mode and
// counter update between the input register and the two-entry result buffer sets this figure.
// Input ready drops only when the input register and both buffer entries are full.
// Reset (asynchronous, active low) clears mode, settings, counters and buffers,
// and loads ticks_per_minute with 14648.
module two_phase_talk_timer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  tptt_in_if.sink           in_i,
  tptt_out_if.source        out_o
);
  import tptt_pkg::*;

  tptt_item_t in_item;
  tptt_item_t s1_item;
  logic       s1_valid;
  logic       fifo_space;
  logic       step;
  tptt_res_t  core_res;
  tptt_res_t  out_res;

  assign in_item.set_press   = in_i.set_press;
  assign in_item.plus_press  = in_i.plus_press;
  assign in_item.minus_press = in_i.minus_press;
  assign in_item.tick        = in_i.tick;

  assign step = s1_valid && fifo_space;

  tptt_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .item_i    (in_item),
    .ready_o   (in_i.ready),
    .advance_i (step),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  tptt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (s1_item),
    .res_o       (core_res)
  );

  tptt_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .data_i  (core_res),
    .space_o (fifo_space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_res)
  );

  assign out_o.level_leds = out_res.level_leds;
  assign out_o.talk_led   = out_res.talk_led;
  assign out_o.green_led  = out_res.green_led;
  assign out_o.red_led    = out_res.red_led;
  assign out_o.blue_led   = out_res.blue_led;
  assign out_o.mode       = out_res.mode;
endmodule

// File: design/tptt_checker.sv
// Port-level checks for the talk timer, bound to the top level.
module tptt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] level_leds_i,
  input logic       talk_led_i,
  input logic       green_led_i,
  input logic       red_led_i,
  input logic       blue_led_i,
  input logic [2:0] mode_i
);
  import tptt_pkg::*;

  logic [2:0] inflight_q, inflight_d;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_beat && !out_beat) begin
      inflight_d = inflight_q + 3'd1;
    end else if (out_beat && !in_beat) begin
      inflight_d = inflight_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 3'd0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // Every result beat must stem from an accepted poll beat.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (inflight_q != 3'd0))
    else $error("result offered with no poll in flight");

  // The input register plus two buffer entries bound the beats in flight.
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3)
    else $error("more poll beats in flight than the design can hold");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(level_leds_i) && $stable(mode_i) &&
       $stable(red_led_i) && $stable(blue_led_i)))
    else $error("stalled result beat changed");

  // Blue only shows in the question warning minute, together with red and green.
  a_blue_warn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && blue_led_i) |->
      (red_led_i && green_led_i && !talk_led_i && (mode_i == MODE_RUN_QUEST)))
    else $error("blue LED outside the question warning minute");
endmodule

bind two_phase_talk_timer tptt_checker u_tptt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .level_leds_i (out_o.level_leds),
  .talk_led_i   (out_o.talk_led),
  .green_led_i  (out_o.green_led),
  .red_led_i    (out_o.red_led),
  .blue_led_i   (out_o.blue_led),
  .mode_i       (out_o.mode)
);

// File: dv/tb_two_phase_talk_timer.sv
// Testbench for the two-phase talk timer: predicts every LED beat and checks it.
module tb_two_phase_talk_timer;
  import tptt_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned PhaseLen   = 160;

  class led_board;
    tptt_mode_e  mode;
    logic [7:0]  talk_min;
    logic [7:0]  quest_min;
    logic [7:0]  min_cnt;
    logic [15:0] tick_cnt;
    logic [15:0] tpm;
    logic        warn;
    tptt_res_t   led_due[$];
    int unsigned mismatches;

    function new();
      mode       = MODE_SET_TALK;
      talk_min   = '0;
      quest_min  = '0;
      min_cnt    = '0;
      tick_cnt   = '0;
      tpm        = TicksReset;
      warn       = 1'b0;
      mismatches = 0;
    endfunction

    function logic [7:0] nudge(logic [7:0] v, logic up, logic down);
      if (up) return v + 8'd1;
      if (down && v != 8'd0) return v - 8'd1;
      return v;
    endfunction

    function void begin_run(tptt_mode_e m);
      mode     = m;
      tick_cnt = '0;
      min_cnt  = '0;
      warn     = 1'b0;
    endfunction

    function void run_step(logic tk, logic [7:0] goal, tptt_mode_e done_m);
      if (tk) begin
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt == tpm) begin
          tick_cnt = '0;
          min_cnt  = min_cnt + 8'd1;
        end
      end
      // Warning lights when one minute of the phase is left.
      if ({1'b0, min_cnt} + 9'd1 == {1'b0, goal}) warn = 1'b1;
      if (min_cnt >= goal) mode = done_m;
    endfunction

    function void note_poll(tptt_item_t p);
      tptt_res_t r;
      case (mode)
        MODE_SET_QUEST: begin
          if (p.set_press) begin_run(MODE_RUN_TALK);
          else quest_min = nudge(quest_min, p.plus_press, p.minus_press);
        end
        MODE_RUN_TALK:   run_step(p.tick, talk_min, MODE_TALK_DONE);
        MODE_TALK_DONE:  if (p.set_press) begin_run(MODE_RUN_QUEST);
        MODE_RUN_QUEST:  run_step(p.tick, quest_min, MODE_QUEST_DONE);
        MODE_QUEST_DONE: if (p.set_press) begin_run(MODE_RUN_TALK);
        default: begin
          mode = MODE_SET_TALK;
          if (p.set_press) mode = MODE_SET_QUEST;
          else talk_min = nudge(talk_min, p.plus_press, p.minus_press);
        end
      endcase

      r = '0;
      r.mode = mode;
      r.level_leds = min_cnt[3:0] & LevelMask;
      case (mode)
        MODE_SET_TALK: begin
          r.level_leds = talk_min[3:0] & LevelMask;
          r.talk_led   = 1'b1;
        end
        MODE_SET_QUEST: r.level_leds = quest_min[3:0] & LevelMask;
        MODE_RUN_TALK: begin
          r.talk_led  = 1'b1;
          r.green_led = 1'b1;
          r.red_led   = warn;
        end
        MODE_TALK_DONE: begin
          r.talk_led = 1'b1;
          r.red_led  = 1'b1;
        end
        MODE_RUN_QUEST: begin
          r.green_led = 1'b1;
          r.red_led   = warn;
          r.blue_led  = warn;
        end
        default: r.red_led = 1'b1;
      endcase
      led_due.push_back(r);
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_leds(tptt_res_t got);
      tptt_res_t want;
      if (led_due.size() == 0) begin
        $error("LED beat with nothing expected: %0h", got);
        mismatches++;
        return;
      end
      want = led_due.pop_front();
      cmp("level_leds", 8'(want.level_leds), 8'(got.level_leds));
      cmp("talk_led", 8'(want.talk_led), 8'(got.talk_led));
      cmp("green_led", 8'(want.green_led), 8'(got.green_led));
      cmp("red_led", 8'(want.red_led), 8'(got.red_led));
      cmp("blue_led", 8'(want.blue_led), 8'(got.blue_led));
      cmp("mode", 8'(want.mode), 8'(got.mode));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  int unsigned cycles;
  logic [15:0] tick_plan [8];
  led_board    board;

  tptt_in_if  in_if ();
  tptt_out_if out_if ();

  two_phase_talk_timer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: a long hold-off takes precedence over the random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      board.check_leds({out_if.level_leds, out_if.talk_led, out_if.green_led,
                        out_if.red_led, out_if.blue_led, out_if.mode});
    end
  end

  function automatic tptt_item_t poll(bit s, bit pl, bit mi, bit tk);
    tptt_item_t p;
    p.set_press   = s;
    p.plus_press  = pl;
    p.minus_press = mi;
    p.tick        = tk;
    return p;
  endfunction

  function automatic bit coin();
    return bit'($urandom_range(1));
  endfunction

  // Mostly well-formed polls for the current mode, with some raw noise.
  function automatic tptt_item_t pick_poll();
    tptt_item_t p;
    p = tptt_item_t'(4'($urandom_range(15)));
    if ($urandom_range(99) < 10) return p;
    case (board.mode)
      MODE_RUN_TALK, MODE_RUN_QUEST: begin
        p.tick      = ($urandom_range(99) < 80);
        p.set_press = ($urandom_range(99) < 10);
      end
      MODE_TALK_DONE, MODE_QUEST_DONE: p.set_press = ($urandom_range(99) < 35);
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_poll(input tptt_item_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.set_press   <= p.set_press;
    in_if.plus_press  <= p.plus_press;
    in_if.minus_press <= p.minus_press;
    in_if.tick        <= p.tick;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.note_poll(p);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (board.led_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ticks(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.tpm = v;
  endtask

  initial begin
    int unsigned qgoal;

    board             = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.set_press   = 1'b0;
    in_if.plus_press  = 1'b0;
    in_if.minus_press = 1'b0;
    in_if.tick        = 1'b0;
    out_if.ready      = 1'b0;
    idle_pct          = 0;
    stall_pct         = 0;
    hold_left         = 0;
    cycles            = 0;
    tick_plan = '{16'd1, 16'd3, 16'd65535, 16'd2, 16'd1, 16'd6, 16'd4, 16'd2};
    qgoal = $urandom_range(5, 2);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Talk setting: minus stops at zero, plus beats minus, tick is ignored.
    send_poll(poll(0, 0, 1, 0));
    send_poll(poll(0, 1, 0, 0));
    send_poll(poll(0, 1, 1, 1));
    send_poll(poll(0, 0, 1, 0));
    send_poll(poll(0, 0, 0, 1));
    send_poll(poll(0, 0, 0, 0));
    // Climb through every value and wrap back to a zero talk setting.
    repeat (255) send_poll(poll(0, 1, coin(), coin()));
    // Set wins over plus and minus.
    send_poll(poll(1, 1, 1, 1));
    send_poll(poll(0, 0, 1, 1));
    repeat (qgoal + 1) send_poll(poll(0, 1, coin(), coin()));
    send_poll(poll(0, 0, 1, 0));
    send_poll(poll(1, 1, 0, 1));
    // Zero talk setting finishes on the first running poll; buttons ignored.
    send_poll(poll(0, 1, 0, 1));
    send_poll(poll(0, 1, 1, 1));
    send_poll(poll(1, 0, 0, 0));

    // Lower the register below the tick count mid-run: no minute passes
    // until the count wraps.
    drain_results();
    write_ticks(16'd100);
    repeat (50) send_poll(poll(0, coin(), coin(), 1));
    drain_results();
    write_ticks(16'd10);
    repeat (40) send_poll(poll(0, coin(), coin(), 1));

    // A zero register gives no minute until the 16-bit tick count wraps.
    drain_results();
    write_ticks(16'd0);
    repeat (40) send_poll(poll(0, coin(), coin(), 1));

    // Match the register to the next tick so the question run moves on.
    drain_results();
    write_ticks(board.tick_cnt + 16'd1);
    send_poll(poll(0, 0, 0, 1));

    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      write_ticks(tick_plan[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      for (int k = 0; k < PhaseLen; k++) begin
        if (ph == 1 && k == PhaseLen / 2) hold_left = 60;
        if (ph == 2 && k == PhaseLen / 2) drain_results();
        send_poll(pick_poll());
      end
    end

    idle_pct  = 0;
    stall_pct = 0;
    drain_results();
    repeat (10) @(negedge clk);
    if (board.mismatches == 0 && board.led_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
